### rtl/plc_pkg.sv
package plc_pkg;

  // Field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 9;

  // Request kinds
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } plc_op_t;

  // Answer codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } plc_status_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;   // open a hole at the position, load the new element there
    logic rem;   // close the hole at the position
    logic pick;  // cell at the position drives its element onto the gather tree
  } plc_ctrl_t;

endpackage

### rtl/plc_cell.sv
module plc_cell
  import plc_pkg::*;
#(
  parameter int unsigned IW = 8
) (
  input  logic              clk,
  input  plc_ctrl_t         ctrl,
  input  logic [IW-1:0]     idx,       // this cell's place in the row
  input  logic [IW-1:0]     pos,       // target place of the request
  input  logic [DATA_W-1:0] new_val,   // element being inserted
  input  logic [DATA_W-1:0] left_val,  // neighbor toward the front
  input  logic [DATA_W-1:0] right_val, // neighbor toward the tail
  output logic [DATA_W-1:0] val,
  output logic [DATA_W-1:0] pick_val
);

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic              at_pos;
  logic              past_pos;

  assign at_pos   = (idx == pos);
  assign past_pos = (idx > pos);

  // Shift toward tail on insert, toward front on remove
  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (at_pos) begin
        val_nxt = new_val;
      end else if (past_pos) begin
        val_nxt = left_val;
      end
    end else if (ctrl.rem) begin
      if (at_pos || past_pos) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val      = val_r;
  assign pick_val = (ctrl.pick && at_pos) ? val_r : '0;

endmodule

### rtl/positional_list_store.sv
// Channel | Direction | tdata (low bit up)              | tuser (low bit up)
// in_     | slave     | position[8:0], value[40:9]      | op[1:0], at_end[2]
// out_    | master    | data[31:0], length[40:32]       | status[1:0]
//
// Each request is accepted in S_IDLE; in S_SEL every cell of the row shifts
// or holds and the addressed element is gathered into group registers of 16
// cells, and S_FOLD folds the groups into the result.
// Reset (rst_n low, synchronous) empties the list; element storage is not
// cleared. A stalled result is held in the output register; the next request
// may be accepted and applied meanwhile, but waits for that register to free.
module positional_list_store
  import plc_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // position[8:0], value[40:9], zero pad
  input  logic [2:0]  in_tuser,   // op[1:0], at_end[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // data[31:0], length[40:32], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int unsigned IW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW  = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned GRP   = 16;
  localparam int unsigned NGRP  = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SEL  = 3'b010,
    S_FOLD = 3'b100
  } plc_state_t;

  plc_state_t state_r, state_nxt;

  logic [CW-1:0]     count_r, count_nxt;
  plc_op_t           op_r;
  plc_status_t       status_r;
  logic [IW-1:0]     pos_r;
  logic [DATA_W-1:0] value_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic [LEN_W-1:0]  out_len_r;
  plc_status_t       out_status_r;

  // Input fields
  plc_op_t           in_op;
  logic              in_at_end;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_value;

  assign in_op     = plc_op_t'(in_tuser[1:0]);
  assign in_at_end = in_tuser[2];
  assign in_pos    = in_tdata[8:0];
  assign in_value  = in_tdata[40:9];

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Target position and status of the incoming request
  logic [CMPW-1:0] count_x;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cap_x;
  logic [CMPW-1:0] eff_x;
  plc_status_t     chk_status;

  assign count_x = CMPW'(count_r);
  assign pos_x   = CMPW'(in_pos);
  assign cap_x   = CMPW'(CAPACITY);

  always_comb begin
    eff_x      = pos_x;
    chk_status = ST_OK;
    case (in_op)
      OP_INSERT: begin
        if (in_at_end) begin
          eff_x = count_x;
        end
        if (count_x >= cap_x) begin
          chk_status = ST_FULL;
        end else if (eff_x > count_x) begin
          chk_status = ST_BADPOS;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (in_at_end) begin
          eff_x = count_x - CMPW'(1);
        end
        if (count_x == '0) begin
          chk_status = ST_EMPTY;
        end else if (eff_x >= count_x) begin
          chk_status = ST_BADPOS;
        end
      end
      default: begin
        chk_status = ST_OK;
      end
    endcase
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_op;
      status_r <= chk_status;
      pos_r    <= eff_x[IW-1:0];
      value_r  <= in_value;
    end
  end

  // Command to the row
  plc_ctrl_t ctrl;
  logic      req_ok;

  assign req_ok    = (state_r == S_SEL) && (status_r == ST_OK);
  assign ctrl.ins  = req_ok && (op_r == OP_INSERT);
  assign ctrl.rem  = req_ok && (op_r == OP_REMOVE);
  assign ctrl.pick = req_ok && ((op_r == OP_REMOVE) || (op_r == OP_READ));

  // Row of cells
  logic [DATA_W-1:0] cell_val  [CAPACITY];
  logic [DATA_W-1:0] pick_pad  [NGRP*GRP];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;
    if (i == 0) begin : g_front
      assign left_w = value_r;
    end else begin : g_mid_l
      assign left_w = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_val[i+1];
    end
    plc_cell #(
      .IW(IW)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .idx      (IW'(i)),
      .pos      (pos_r),
      .new_val  (value_r),
      .left_val (left_w),
      .right_val(right_w),
      .val      (cell_val[i]),
      .pick_val (pick_pad[i])
    );
  end

  for (genvar i = CAPACITY; i < NGRP*GRP; i++) begin : g_pad
    assign pick_pad[i] = '0;
  end

  // Gather tree, first level: one register per group of cells
  logic [DATA_W-1:0] grp_r   [NGRP];
  logic [DATA_W-1:0] grp_nxt [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        grp_nxt[g] = grp_nxt[g] | pick_pad[g*GRP + k];
      end
    end
    always_ff @(posedge clk) begin
      if (state_r == S_SEL) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // Gather tree, second level
  logic [DATA_W-1:0] fold_val;

  always_comb begin
    fold_val = '0;
    for (int g = 0; g < NGRP; g++) begin
      fold_val = fold_val | grp_r[g];
    end
  end

  // Element count
  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.rem) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // Sequencer
  logic out_load;
  assign out_load = (state_r == S_FOLD) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register; length is the count modulo 512
  logic [CW+LEN_W-1:0] len_ext;
  assign len_ext = {{LEN_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r   <= fold_val;
      out_len_r    <= len_ext[LEN_W-1:0];
      out_status_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_len_r, out_data_r};
  assign out_tuser  = out_status_r;

endmodule
